[rtl/dssg_pkg.sv]
package dssg_pkg;

  localparam int SPEED_W = 24;
  localparam int MAG_W   = 23;
  localparam int PT_W    = 8;
  localparam int PHASE_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int TICK_HZ = 50000;
  localparam int TICK_W  = $clog2(TICK_HZ + 1);

  // increment = floor(mag * 2^STEP_SH / TICK_HZ)
  localparam int STEP_SH = 24;

  // quotient a = floor(mag / TICK_HZ), exact reciprocal
  localparam int DIVA_SH = MAG_W + TICK_W;
  localparam longint unsigned DIVA_M =
    ((64'd1 << DIVA_SH) + 64'(TICK_HZ) - 64'd1) / 64'(TICK_HZ);
  localparam int DIVA_MW = MAG_W + 2;
  localparam int PA_W    = MAG_W + DIVA_MW;
  localparam int QUO_W   = MAG_W + 1 - TICK_W;

  // fraction floor(b * 2^STEP_SH / TICK_HZ) for remainder b, exact reciprocal
  localparam int DIVB_SH = 2 * TICK_W;
  localparam longint unsigned DIVB_H   = 64'd1 << (STEP_SH - 1 + DIVB_SH);
  localparam longint unsigned DIVB_HQ  = DIVB_H / 64'(TICK_HZ);
  localparam longint unsigned DIVB_HR2 = 2 * (DIVB_H % 64'(TICK_HZ));
  localparam longint unsigned DIVB_F   =
    2 * DIVB_HQ + ((DIVB_HR2 >= 64'(TICK_HZ)) ? 64'd1 : 64'd0);
  localparam longint unsigned DIVB_R   =
    (DIVB_HR2 >= 64'(TICK_HZ)) ? DIVB_HR2 - 64'(TICK_HZ) : DIVB_HR2;
  localparam longint unsigned DIVB_M   = DIVB_F + ((DIVB_R != 64'd0) ? 64'd1 : 64'd0);
  localparam int DIVB_MW = STEP_SH + 2 + TICK_W;
  localparam int PB_W    = TICK_W + DIVB_MW;

  localparam int INC_FULL_W = QUO_W + STEP_SH;
  localparam longint unsigned PHASE_MAX = (64'd1 << PHASE_W) - 64'd1;

  localparam logic [MAG_W-1:0] SPEED_LIM_RST = 23'd512000;
  localparam logic [MAG_W-1:0] DEADBAND_RST  = 23'd256;
  localparam logic [PT_W-1:0]  PULSE_RST     = 8'd1;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_SET  = 2'd1,
    MODE_STOP = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    MOT_STOP = 2'd0,
    MOT_FWD  = 2'd1,
    MOT_BWD  = 2'd2
  } motion_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_LIM = 3'd0,
    CFG_DEADBAND  = 3'd1,
    CFG_PULSE     = 3'd2,
    CFG_INV_LEFT  = 3'd3,
    CFG_INV_RIGHT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  typedef struct packed {
    logic [MAG_W-1:0] speed_lim;
    logic [MAG_W-1:0] deadband;
    logic             invert;
  } lane_cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] inc;
    logic               dir;
    motion_t            motion;
  } lane_set_t;

endpackage

[rtl/dssg_rate_lane.sv]
module dssg_rate_lane
  import dssg_pkg::*;
(
  input  logic                      clk,
  input  pipe_en_t                  en,
  input  lane_cfg_t                 cfg,
  input  logic signed [SPEED_W-1:0] speed,
  output lane_set_t                 set_o
);

  // stage 1: clamp, magnitude, direction and motion
  logic [MAG_W-1:0]   mag1_r;
  logic               dir1_r, zero1_r;
  motion_t            mot1_r;
  // stage 2: quotient product
  logic [PA_W-1:0]    prod1_r;
  logic [MAG_W-1:0]   mag2_r;
  logic               dir2_r, zero2_r;
  motion_t            mot2_r;
  // stage 3: quotient and remainder
  logic [QUO_W-1:0]   quo3_r;
  logic [TICK_W-1:0]  rem3_r;
  logic               dir3_r, zero3_r;
  motion_t            mot3_r;
  // stage 4: fraction product
  logic [QUO_W-1:0]   quo4_r;
  logic [PB_W-1:0]    prod2_r;
  logic               dir4_r, zero4_r;
  motion_t            mot4_r;

  logic               sgn;
  logic [SPEED_W-1:0] abs_s;
  logic [MAG_W-1:0]   mag;
  logic               pos, below, above;
  logic               dir_nxt;
  motion_t            mot_nxt;
  logic [MAG_W-1:0]   rem_full;
  logic [INC_FULL_W-1:0] inc_full;
  logic               sat;

  always_comb begin
    sgn   = speed[SPEED_W-1];
    abs_s = sgn ? SPEED_W'(-speed) : SPEED_W'(speed);
    mag   = (abs_s > {1'b0, cfg.speed_lim}) ? cfg.speed_lim : abs_s[MAG_W-1:0];
    pos   = !sgn && (mag != '0);
    below = mag < cfg.deadband;
    above = mag > cfg.deadband;
    dir_nxt = below ? 1'b0 : (pos ^ cfg.invert);
    if (above) begin
      mot_nxt = pos ? MOT_FWD : MOT_BWD;
    end else begin
      mot_nxt = MOT_STOP;
    end
  end

  assign rem_full = mag2_r - (MAG_W'(prod1_r[DIVA_SH +: QUO_W]) * MAG_W'(TICK_HZ));

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag1_r  <= mag;
      dir1_r  <= dir_nxt;
      mot1_r  <= mot_nxt;
      zero1_r <= below;
    end
    if (en.s2) begin
      prod1_r <= PA_W'(mag1_r) * PA_W'(DIVA_M);
      mag2_r  <= mag1_r;
      dir2_r  <= dir1_r;
      mot2_r  <= mot1_r;
      zero2_r <= zero1_r;
    end
    if (en.s3) begin
      quo3_r  <= prod1_r[DIVA_SH +: QUO_W];
      rem3_r  <= rem_full[TICK_W-1:0];
      dir3_r  <= dir2_r;
      mot3_r  <= mot2_r;
      zero3_r <= zero2_r;
    end
    if (en.s4) begin
      quo4_r  <= quo3_r;
      prod2_r <= PB_W'(rem3_r) * PB_W'(DIVB_M);
      dir4_r  <= dir3_r;
      mot4_r  <= mot3_r;
      zero4_r <= zero3_r;
    end
  end

  always_comb begin
    inc_full = {quo4_r, prod2_r[DIVB_SH +: STEP_SH]};
    sat      = 64'(inc_full) > PHASE_MAX;
    if (zero4_r) begin
      set_o.inc = '0;
    end else if (sat) begin
      set_o.inc = '1;
    end else begin
      set_o.inc = PHASE_W'(inc_full);
    end
    set_o.dir    = dir4_r;
    set_o.motion = mot4_r;
  end

endmodule

[rtl/dssg_step_lane.sv]
module dssg_step_lane
  import dssg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  mode_t           mode,
  input  lane_set_t       set_i,
  input  logic [PT_W-1:0] pulse_width,
  output logic            step,
  output logic            dir,
  output motion_t         motion
);

  logic [PHASE_W-1:0] acc_r, acc_nxt;
  logic [PHASE_W-1:0] inc_r, inc_nxt;
  logic [PT_W-1:0]    cnt_r, cnt_nxt;
  logic               step_r, step_nxt;
  logic               dir_r, dir_nxt;
  motion_t            mot_r, mot_nxt;

  logic [PT_W-1:0]    cnt_dec;
  logic               carry;
  logic [PHASE_W-1:0] sum;
  logic [PT_W-1:0]    pt_eff;

  always_comb begin
    acc_nxt  = acc_r;
    inc_nxt  = inc_r;
    cnt_nxt  = cnt_r;
    step_nxt = step_r;
    dir_nxt  = dir_r;
    mot_nxt  = mot_r;
    cnt_dec  = (cnt_r != '0) ? cnt_r - PT_W'(1) : cnt_r;
    {carry, sum} = {1'b0, acc_r} + {1'b0, inc_r};
    pt_eff   = (pulse_width == '0) ? PT_W'(1) : pulse_width;
    if (en) begin
      unique case (mode)
        MODE_TICK: begin
          cnt_nxt = cnt_dec;
          if (cnt_r != '0 && cnt_dec == '0) begin
            step_nxt = 1'b0;
          end
          if (inc_r != '0) begin
            acc_nxt = sum;
            // new pulse only once the previous one has ended
            if (carry && cnt_dec == '0) begin
              step_nxt = 1'b1;
              cnt_nxt  = pt_eff;
            end
          end
        end
        MODE_SET: begin
          inc_nxt = set_i.inc;
          dir_nxt = set_i.dir;
          mot_nxt = set_i.motion;
        end
        MODE_STOP: begin
          inc_nxt  = '0;
          cnt_nxt  = '0;
          step_nxt = 1'b0;
          mot_nxt  = MOT_STOP;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      inc_r  <= '0;
      cnt_r  <= '0;
      step_r <= 1'b0;
      dir_r  <= 1'b0;
      mot_r  <= MOT_STOP;
    end else begin
      acc_r  <= acc_nxt;
      inc_r  <= inc_nxt;
      cnt_r  <= cnt_nxt;
      step_r <= step_nxt;
      dir_r  <= dir_nxt;
      mot_r  <= mot_nxt;
    end
  end

  assign step   = step_r;
  assign dir    = dir_r;
  assign motion = mot_r;

endmodule

[rtl/dual_stepper_step_generator_unit.sv]
// Two-motor step/direction generator.
// Input channel (in_valid/in_stall): in_mode selects tick, set speeds or stop;
// in_speed_left/in_speed_right are signed Q16.8 steps/s, read only for set speeds.
// Output channel (out_valid/out_stall): one item per input item carrying the
// STEP, DIR and motion levels of both motors after that item, plus running.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (speed clamp,
// deadband, pulse width, left invert, right invert); write only while idle.
// out_valid rises once an item has passed the pipeline stages and the output
// register. Throughput: one item per cycle while out_stall is low; the increment
// divide is split over four pipeline stages per motor (clamp, quotient multiply,
// remainder, fraction multiply) and the motor state updates as the item enters
// the output register, so a tick may directly follow a speed change.
// A stalled result holds in the output register; the stages ahead keep filling
// until the pipeline is full, then in_stall rises.
// Reset (rst_n low, synchronous) clears phases, increments, pulse counts and
// levels, empties the pipeline and loads the register defaults.
module dual_stepper_step_generator_unit
  import dssg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic signed [SPEED_W-1:0]    in_speed_left,
  input  logic signed [SPEED_W-1:0]    in_speed_right,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_step_left,
  output logic                         out_step_right,
  output logic                         out_dir_left,
  output logic                         out_dir_right,
  output logic [1:0]                   out_motion_left,
  output logic [1:0]                   out_motion_right,
  output logic                         out_running,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  logic [MAG_W-1:0] speed_lim_r;
  logic [MAG_W-1:0] deadband_r;
  logic [PT_W-1:0]  pulse_width_r;
  logic             inv_left_r, inv_right_r;

  logic  v1_r, v2_r, v3_r, v4_r, out_valid_r;
  mode_t mode1_r, mode2_r, mode3_r, mode4_r;
  logic  rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic  upd;

  pipe_en_t  pen;
  lane_cfg_t cfg_l, cfg_r;
  lane_set_t set_l, set_r;
  motion_t   mot_l, mot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_lim_r   <= SPEED_LIM_RST;
      deadband_r    <= DEADBAND_RST;
      pulse_width_r <= PULSE_RST;
      inv_left_r    <= 1'b0;
      inv_right_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPEED_LIM: speed_lim_r   <= cfg_wdata[MAG_W-1:0];
        CFG_DEADBAND:  deadband_r    <= cfg_wdata[MAG_W-1:0];
        CFG_PULSE:     pulse_width_r <= cfg_wdata[PT_W-1:0];
        CFG_INV_LEFT:  inv_left_r    <= cfg_wdata[0];
        CFG_INV_RIGHT: inv_right_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // each stage moves when it is empty or its successor moves
  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy4     = !v4_r || rdy_out;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign upd      = v4_r && rdy_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy4)    v4_r        <= v3_r;
      if (rdy_out) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) mode1_r <= mode_t'(in_mode);
    if (rdy2) mode2_r <= mode1_r;
    if (rdy3) mode3_r <= mode2_r;
    if (rdy4) mode4_r <= mode3_r;
  end

  always_comb begin
    pen.s1 = rdy1;
    pen.s2 = rdy2;
    pen.s3 = rdy3;
    pen.s4 = rdy4;
    cfg_l.speed_lim = speed_lim_r;
    cfg_l.deadband  = deadband_r;
    cfg_l.invert    = inv_left_r;
    cfg_r.speed_lim = speed_lim_r;
    cfg_r.deadband  = deadband_r;
    cfg_r.invert    = inv_right_r;
  end

  dssg_rate_lane u_rate_left (
    .clk   (clk),
    .en    (pen),
    .cfg   (cfg_l),
    .speed (in_speed_left),
    .set_o (set_l)
  );

  dssg_rate_lane u_rate_right (
    .clk   (clk),
    .en    (pen),
    .cfg   (cfg_r),
    .speed (in_speed_right),
    .set_o (set_r)
  );

  dssg_step_lane u_step_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (upd),
    .mode        (mode4_r),
    .set_i       (set_l),
    .pulse_width (pulse_width_r),
    .step        (out_step_left),
    .dir         (out_dir_left),
    .motion      (mot_l)
  );

  dssg_step_lane u_step_right (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (upd),
    .mode        (mode4_r),
    .set_i       (set_r),
    .pulse_width (pulse_width_r),
    .step        (out_step_right),
    .dir         (out_dir_right),
    .motion      (mot_r)
  );

  // lane state only changes when the output register is free, so it is the result
  assign out_valid        = out_valid_r;
  assign out_motion_left  = mot_l;
  assign out_motion_right = mot_r;
  assign out_running      = (mot_l != MOT_STOP) || (mot_r != MOT_STOP);

endmodule
